FILE: rtl/core/dwtp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drawn waveform table player package
// Shared widths, operation codes, register indexes, controller states and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package dwtp_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int AW          = $clog2(MAX_SAMPLES);

  localparam int OP_W   = 3;
  localparam int POS_W  = 12;
  localparam int LVL_W  = 10;
  localparam int VW_W   = 11;
  localparam int VH_W   = 12;
  localparam int NW     = ((AW + 1) > VW_W) ? (AW + 1) : VW_W;

  localparam int DIV_NW = VH_W + LVL_W;
  localparam int DIV_DW = VH_W;
  localparam int DIV_CW = $clog2(DIV_NW + 1);

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [LVL_W-1:0] MID_LEVEL       = 10'd512;
  localparam logic [VW_W-1:0]  VIEW_WIDTH_RST  = 11'd1024;
  localparam logic [VH_W-1:0]  VIEW_HEIGHT_RST = 12'd600;

  localparam logic [1:0] REG_VIEW_WIDTH  = 2'd0;
  localparam logic [1:0] REG_VIEW_HEIGHT = 2'd1;
  localparam logic [1:0] REG_LOOP_ENABLE = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_PEN_DOWN   = 3'd0,
    OP_PEN_MOVE   = 3'd1,
    OP_PEN_UP     = 3'd2,
    OP_TICK       = 3'd3,
    OP_PLAY_START = 3'd4,
    OP_PLAY_STOP  = 3'd5,
    OP_CLEAR      = 3'd6
  } op_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_TICK,
    S_PEN_ADDR,
    S_PEN_READ,
    S_LEVEL,
    S_SLOPE_GO,
    S_SLOPE,
    S_RAMP
  } state_t;

  typedef struct packed {
    logic latch_item;
    logic lv_clr;
    logic play_start;
    logic play_stop;
    logic tick_rd;
    logic tick_emit;
    logic sweep_wr;
    logic pen_addr;
    logic s0_ld;
    logic div_start;
    logic div_sel_slope;
    logic lvl_ld;
    logic slope_ld;
    logic point_wr;
    logic ramp_wr;
    logic pen_done;
  } dp_cmd_t;

  typedef struct packed {
    logic playing;
    logic div_done;
    logic sweep_last;
    logic dzero;
    logic ramp_last;
  } dp_stat_t;

endpackage

FILE: rtl/core/dwtp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module dwtp_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/dwtp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial divider
// Unsigned restoring division, one quotient bit per cycle, done pulse at end.
// ----------------------------------------------------------------------------
module dwtp_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [dwtp_pkg::DIV_NW-1:0] dividend,
  input  logic [dwtp_pkg::DIV_DW-1:0] divisor,
  output logic [dwtp_pkg::DIV_NW-1:0] quotient,
  output logic [dwtp_pkg::DIV_DW-1:0] remainder,
  output logic                        done
);

  logic                        active_r;
  logic                        done_r;
  logic [dwtp_pkg::DIV_CW-1:0] cnt_r;
  logic [dwtp_pkg::DIV_NW-1:0] quo_r;
  logic [dwtp_pkg::DIV_DW-1:0] rem_r;
  logic [dwtp_pkg::DIV_DW-1:0] dvs_r;
  logic [dwtp_pkg::DIV_DW:0]   shifted_c;
  logic                        fits_c;

  assign shifted_c = {rem_r, quo_r[dwtp_pkg::DIV_NW-1]};
  assign fits_c    = shifted_c >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        active_r <= 1'b1;
        cnt_r    <= dwtp_pkg::DIV_CW'(dwtp_pkg::DIV_NW);
      end else if (active_r) begin
        cnt_r <= cnt_r - dwtp_pkg::DIV_CW'(1);
        if (cnt_r == dwtp_pkg::DIV_CW'(1)) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (active_r) begin
      if (fits_c) begin
        rem_r <= dwtp_pkg::DIV_DW'(shifted_c - {1'b0, dvs_r});
        quo_r <= {quo_r[dwtp_pkg::DIV_NW-2:0], 1'b1};
      end else begin
        rem_r <= shifted_c[dwtp_pkg::DIV_DW-1:0];
        quo_r <= {quo_r[dwtp_pkg::DIV_NW-2:0], 1'b0};
      end
    end
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign done      = done_r;

endmodule

FILE: rtl/core/dwtp_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drawn waveform table player datapath
// Configuration registers, pen and playback state, sample store, divider and
// the ramp stepper, all driven by controller commands.
// ----------------------------------------------------------------------------
module dwtp_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dwtp_pkg::dp_cmd_t            cmd,
  output dwtp_pkg::dp_stat_t           stat,
  input  logic [dwtp_pkg::POS_W-1:0]   in_pos_x,
  input  logic [dwtp_pkg::POS_W-1:0]   in_pos_y,
  output logic                         out_valid,
  output logic [dwtp_pkg::LVL_W-1:0]   out_setpoint,
  output logic                         out_pass_end,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dwtp_pkg::PADDR_W-1:0] paddr,
  input  logic [dwtp_pkg::PDATA_W-1:0] pwdata,
  output logic [dwtp_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  localparam int AW    = dwtp_pkg::AW;
  localparam int LVL_W = dwtp_pkg::LVL_W;
  localparam int NW    = dwtp_pkg::NW;
  localparam int POS_W = dwtp_pkg::POS_W;
  localparam int VH_W  = dwtp_pkg::VH_W;
  localparam int VW_W  = dwtp_pkg::VW_W;

  // configuration
  logic [VW_W-1:0] view_width_r;
  logic [VH_W-1:0] view_height_r;
  logic            loop_enable_r;
  logic            cfg_wr_c;
  logic [1:0]      reg_idx_c;

  // state
  logic [POS_W-1:0] x_r;
  logic [POS_W-1:0] y_r;
  logic [AW-1:0]    last_point_r;
  logic             last_valid_r;
  logic [AW-1:0]    play_pos_r;
  logic             playing_r;
  logic             pend_r;
  logic [AW-1:0]    sweep_addr_r;
  logic [AW-1:0]    idx_r;
  logic [AW-1:0]    last_r;
  logic [AW-1:0]    cur_r;
  logic [LVL_W-1:0] s0_r;
  logic [LVL_W-1:0] level_r;
  logic signed [LVL_W:0] qd_r;
  logic [AW-1:0]    rd_r;
  logic signed [LVL_W:0] q_r;
  logic [AW-1:0]    r_r;
  logic             out_valid_r;
  logic [LVL_W-1:0] out_setpoint_r;
  logic             out_pass_end_r;

  // combinational
  logic [NW-1:0]    vw_ext_c;
  logic [NW-1:0]    n_c;
  logic [AW-1:0]    nm1_c;
  logic [AW-1:0]    idx_c;
  logic [AW-1:0]    lsel_c;
  logic [AW-1:0]    last_c;
  logic [AW-1:0]    pos_c;
  logic             endp_c;
  logic [VH_W-1:0]  hm1_c;
  logic signed [VH_W+1:0] vraw_c;
  logic [VH_W-1:0]  v_c;
  logic [dwtp_pkg::DIV_NW-1:0] lvl_dvd_c;
  logic signed [LVL_W:0] diff_c;
  logic signed [LVL_W:0] diff_neg_c;
  logic [LVL_W-1:0] diff_mag_c;
  logic             up_c;
  logic [AW-1:0]    dabs_c;
  logic [dwtp_pkg::DIV_NW-1:0] div_dvd_c;
  logic [dwtp_pkg::DIV_DW-1:0] div_dvs_c;
  logic [dwtp_pkg::DIV_NW-1:0] div_quo;
  logic [dwtp_pkg::DIV_DW-1:0] div_rem;
  logic             div_done;
  logic [LVL_W-1:0] qa_c;
  logic [AW-1:0]    ra_c;
  logic [AW:0]      rsum_c;
  logic signed [LVL_W:0] q_nxt;
  logic [AW-1:0]    r_nxt;
  logic signed [LVL_W:0] ramp_val_c;
  logic             we_c;
  logic [AW-1:0]    waddr_c;
  logic [LVL_W-1:0] wdata_c;
  logic [AW-1:0]    raddr_c;
  logic [LVL_W-1:0] rdata;

  // configuration port
  assign cfg_wr_c  = psel && penable && pwrite;
  assign reg_idx_c = paddr[3:2];
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_width_r  <= dwtp_pkg::VIEW_WIDTH_RST;
      view_height_r <= dwtp_pkg::VIEW_HEIGHT_RST;
      loop_enable_r <= 1'b1;
    end else if (cfg_wr_c) begin
      case (reg_idx_c)
        dwtp_pkg::REG_VIEW_WIDTH:  view_width_r  <= pwdata[VW_W-1:0];
        dwtp_pkg::REG_VIEW_HEIGHT: view_height_r <= pwdata[VH_W-1:0];
        dwtp_pkg::REG_LOOP_ENABLE: loop_enable_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_c)
      dwtp_pkg::REG_VIEW_WIDTH:  prdata = dwtp_pkg::PDATA_W'(view_width_r);
      dwtp_pkg::REG_VIEW_HEIGHT: prdata = dwtp_pkg::PDATA_W'(view_height_r);
      dwtp_pkg::REG_LOOP_ENABLE: prdata = dwtp_pkg::PDATA_W'(loop_enable_r);
      default:                   prdata = '0;
    endcase
  end

  // sample count and index clamps
  assign vw_ext_c = NW'(view_width_r);

  always_comb begin
    if (vw_ext_c == '0) begin
      n_c = NW'(1);
    end else if (vw_ext_c > NW'(dwtp_pkg::MAX_SAMPLES)) begin
      n_c = NW'(dwtp_pkg::MAX_SAMPLES);
    end else begin
      n_c = vw_ext_c;
    end
  end

  assign nm1_c = AW'(n_c - NW'(1));

  always_comb begin
    if (x_r[POS_W-1]) begin
      idx_c = '0;
    end else if (NW'(x_r[POS_W-2:0]) > NW'(nm1_c)) begin
      idx_c = nm1_c;
    end else begin
      idx_c = AW'(x_r[POS_W-2:0]);
    end
  end

  assign lsel_c = last_valid_r ? last_point_r : idx_c;
  assign last_c = (lsel_c > nm1_c) ? nm1_c : lsel_c;
  assign pos_c  = (play_pos_r > nm1_c) ? nm1_c : play_pos_r;
  assign endp_c = pos_c == nm1_c;

  // level from y
  assign hm1_c  = view_height_r - VH_W'(1);
  assign vraw_c = $signed({2'b00, hm1_c})
                - $signed({{(VH_W + 2 - POS_W){y_r[POS_W-1]}}, y_r});

  always_comb begin
    if (vraw_c[VH_W+1]) begin
      v_c = '0;
    end else if (vraw_c[VH_W:0] > {1'b0, hm1_c}) begin
      v_c = hm1_c;
    end else begin
      v_c = vraw_c[VH_W-1:0];
    end
  end

  assign lvl_dvd_c = (dwtp_pkg::DIV_NW'(v_c) << LVL_W) - dwtp_pkg::DIV_NW'(v_c);

  // slope
  assign diff_c     = $signed({1'b0, level_r}) - $signed({1'b0, s0_r});
  assign diff_neg_c = -diff_c;
  assign diff_mag_c = diff_c[LVL_W] ? diff_neg_c[LVL_W-1:0] : diff_c[LVL_W-1:0];
  assign up_c       = idx_r > last_r;
  assign dabs_c     = up_c ? (idx_r - last_r) : (last_r - idx_r);

  assign div_dvd_c = cmd.div_sel_slope ? dwtp_pkg::DIV_NW'(diff_mag_c) : lvl_dvd_c;
  assign div_dvs_c = cmd.div_sel_slope ? dwtp_pkg::DIV_DW'(dabs_c) : hm1_c;

  dwtp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_dvd_c),
    .divisor   (div_dvs_c),
    .quotient  (div_quo),
    .remainder (div_rem),
    .done      (div_done)
  );

  assign qa_c = div_quo[LVL_W-1:0];
  assign ra_c = div_rem[AW-1:0];

  // ramp stepper
  assign rsum_c = {1'b0, r_r} + {1'b0, rd_r};

  always_comb begin
    if (rsum_c >= {1'b0, dabs_c}) begin
      r_nxt = AW'(rsum_c - {1'b0, dabs_c});
      q_nxt = q_r + qd_r + (LVL_W + 1)'(1);
    end else begin
      r_nxt = rsum_c[AW-1:0];
      q_nxt = q_r + qd_r;
    end
  end

  assign ramp_val_c = $signed({1'b0, s0_r}) + q_r;

  // store ports
  always_comb begin
    we_c    = 1'b0;
    waddr_c = cur_r;
    wdata_c = ramp_val_c[LVL_W-1:0];
    if (cmd.sweep_wr) begin
      we_c    = 1'b1;
      waddr_c = sweep_addr_r;
      wdata_c = dwtp_pkg::MID_LEVEL;
    end else if (cmd.point_wr) begin
      we_c    = 1'b1;
      waddr_c = idx_r;
      wdata_c = level_r;
    end else if (cmd.ramp_wr) begin
      we_c = 1'b1;
    end
  end

  assign raddr_c = cmd.tick_rd ? pos_c : last_c;

  dwtp_ram #(
    .WIDTH (LVL_W),
    .DEPTH (dwtp_pkg::MAX_SAMPLES)
  ) u_store (
    .clk   (clk),
    .we    (we_c),
    .waddr (waddr_c),
    .wdata (wdata_c),
    .raddr (raddr_c),
    .rdata (rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_point_r <= '0;
      last_valid_r <= 1'b0;
      play_pos_r   <= '0;
      playing_r    <= 1'b0;
      sweep_addr_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= cmd.tick_emit;
      if (cmd.sweep_wr) begin
        sweep_addr_r <= sweep_addr_r + AW'(1);
      end
      if (cmd.lv_clr) begin
        last_valid_r <= 1'b0;
      end else if (cmd.pen_done) begin
        last_valid_r <= 1'b1;
        last_point_r <= idx_r;
      end
      if (cmd.play_start) begin
        playing_r  <= 1'b1;
        play_pos_r <= '0;
      end else if (cmd.play_stop) begin
        playing_r <= 1'b0;
      end else if (cmd.tick_rd) begin
        if (endp_c) begin
          play_pos_r <= '0;
          if (!loop_enable_r) begin
            playing_r <= 1'b0;
          end
        end else begin
          play_pos_r <= pos_c + AW'(1);
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      x_r <= in_pos_x;
      y_r <= in_pos_y;
    end
    if (cmd.tick_rd) begin
      pend_r <= endp_c;
    end
    if (cmd.tick_emit) begin
      out_setpoint_r <= rdata;
      out_pass_end_r <= pend_r;
    end
    if (cmd.pen_addr) begin
      idx_r <= idx_c;
      last_r <= last_c;
    end
    if (cmd.s0_ld) begin
      s0_r <= rdata;
    end
    if (cmd.lvl_ld) begin
      level_r <= (view_height_r <= VH_W'(1)) ? dwtp_pkg::MID_LEVEL : qa_c;
    end
    if (cmd.slope_ld) begin
      q_r   <= '0;
      r_r   <= '0;
      cur_r <= last_r;
      if (!diff_c[LVL_W]) begin
        qd_r <= $signed({1'b0, qa_c});
        rd_r <= ra_c;
      end else if (ra_c == '0) begin
        qd_r <= -$signed({1'b0, qa_c});
        rd_r <= '0;
      end else begin
        qd_r <= -$signed({1'b0, qa_c}) - (LVL_W + 1)'(1);
        rd_r <= dabs_c - ra_c;
      end
    end else if (cmd.ramp_wr) begin
      q_r   <= q_nxt;
      r_r   <= r_nxt;
      cur_r <= up_c ? (cur_r + AW'(1)) : (cur_r - AW'(1));
    end
  end

  assign out_valid    = out_valid_r;
  assign out_setpoint = out_setpoint_r;
  assign out_pass_end = out_pass_end_r;

  assign stat.playing    = playing_r;
  assign stat.div_done   = div_done;
  assign stat.sweep_last = sweep_addr_r == AW'(dwtp_pkg::MAX_SAMPLES - 1);
  assign stat.dzero      = idx_r == last_r;
  assign stat.ramp_last  = cur_r == idx_r;

endmodule

FILE: rtl/core/dwtp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drawn waveform table player controller
// Sequences store clearing, playback reads and pen strokes over the datapath.
// ----------------------------------------------------------------------------
module dwtp_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [dwtp_pkg::OP_W-1:0]   operation,
  input  dwtp_pkg::dp_stat_t          stat,
  output dwtp_pkg::dp_cmd_t           cmd,
  output logic                        busy
);

  dwtp_pkg::state_t state_r;
  dwtp_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dwtp_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = state_r != dwtp_pkg::S_IDLE;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      dwtp_pkg::S_CLEAR: begin
        cmd.sweep_wr = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = dwtp_pkg::S_IDLE;
        end
      end
      dwtp_pkg::S_IDLE: begin
        if (start) begin
          cmd.latch_item = 1'b1;
          case (dwtp_pkg::op_t'(operation))
            dwtp_pkg::OP_PEN_DOWN: begin
              cmd.lv_clr = 1'b1;
              state_nxt  = dwtp_pkg::S_PEN_ADDR;
            end
            dwtp_pkg::OP_PEN_MOVE: state_nxt = dwtp_pkg::S_PEN_ADDR;
            dwtp_pkg::OP_PEN_UP:   cmd.lv_clr = 1'b1;
            dwtp_pkg::OP_TICK: begin
              if (stat.playing) begin
                cmd.tick_rd = 1'b1;
                state_nxt   = dwtp_pkg::S_TICK;
              end
            end
            dwtp_pkg::OP_PLAY_START: cmd.play_start = 1'b1;
            dwtp_pkg::OP_PLAY_STOP:  cmd.play_stop = 1'b1;
            dwtp_pkg::OP_CLEAR: begin
              cmd.lv_clr = 1'b1;
              state_nxt  = dwtp_pkg::S_CLEAR;
            end
            default: ;
          endcase
        end
      end
      dwtp_pkg::S_TICK: begin
        cmd.tick_emit = 1'b1;
        state_nxt     = dwtp_pkg::S_IDLE;
      end
      dwtp_pkg::S_PEN_ADDR: begin
        cmd.pen_addr  = 1'b1;
        cmd.div_start = 1'b1;
        state_nxt     = dwtp_pkg::S_PEN_READ;
      end
      dwtp_pkg::S_PEN_READ: begin
        cmd.s0_ld = 1'b1;
        state_nxt = dwtp_pkg::S_LEVEL;
      end
      dwtp_pkg::S_LEVEL: begin
        if (stat.div_done) begin
          cmd.lvl_ld = 1'b1;
          state_nxt  = dwtp_pkg::S_SLOPE_GO;
        end
      end
      dwtp_pkg::S_SLOPE_GO: begin
        if (stat.dzero) begin
          cmd.point_wr = 1'b1;
          cmd.pen_done = 1'b1;
          state_nxt    = dwtp_pkg::S_IDLE;
        end else begin
          cmd.div_start     = 1'b1;
          cmd.div_sel_slope = 1'b1;
          state_nxt         = dwtp_pkg::S_SLOPE;
        end
      end
      dwtp_pkg::S_SLOPE: begin
        if (stat.div_done) begin
          cmd.slope_ld = 1'b1;
          state_nxt    = dwtp_pkg::S_RAMP;
        end
      end
      dwtp_pkg::S_RAMP: begin
        cmd.ramp_wr = 1'b1;
        if (stat.ramp_last) begin
          cmd.pen_done = 1'b1;
          state_nxt    = dwtp_pkg::S_IDLE;
        end
      end
      default: state_nxt = dwtp_pkg::S_IDLE;
    endcase
  end

endmodule

FILE: rtl/core/drawn_waveform_table_player_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drawn waveform table player
// Pen events draw ramps into a 1024-entry level store; ticks play it back.
//
//   channel  | handshake                     | payload
//   ---------+-------------------------------+----------------------------------
//   input    | start, busy                   | in_operation, in_pos_x, in_pos_y
//   result   | out_valid (one-cycle strobe)  | out_setpoint, out_pass_end
//   config   | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// Pen up, play start, play stop and ticks while stopped finish in idle without
// raising busy; a playing tick passes through the tick state, its item on the
// result ports as busy goes low again.
// Pen down or move: a level division and, unless the stroke stays on one entry,
// a slope division on the serial divider, then a ramp of up to 1024 store entries.
// After reset and on clear, a pass writes all 1024 entries, one a cycle.
// Results cannot be stalled; busy alone holds off the next item.
// ----------------------------------------------------------------------------
module drawn_waveform_table_player_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [dwtp_pkg::OP_W-1:0]    in_operation,
  input  logic [dwtp_pkg::POS_W-1:0]   in_pos_x,
  input  logic [dwtp_pkg::POS_W-1:0]   in_pos_y,
  output logic                         out_valid,
  output logic [dwtp_pkg::LVL_W-1:0]   out_setpoint,
  output logic                         out_pass_end,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dwtp_pkg::PADDR_W-1:0] paddr,
  input  logic [dwtp_pkg::PDATA_W-1:0] pwdata,
  output logic [dwtp_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  dwtp_pkg::dp_cmd_t  cmd;
  dwtp_pkg::dp_stat_t stat;

  dwtp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .operation (in_operation),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  dwtp_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_pos_x     (in_pos_x),
    .in_pos_y     (in_pos_y),
    .out_valid    (out_valid),
    .out_setpoint (out_setpoint),
    .out_pass_end (out_pass_end),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

endmodule
